### hdl/foiir_pkg.sv
package foiir_pkg;

  localparam int CHANNELS_DEF        = 8;
  localparam int SAMPLE_BITS_DEF     = 24;
  localparam int COEFF_FRAC_BITS_DEF = 16;

  localparam int CHAN_BITS    = 3;
  localparam int COEFF_BITS   = 18;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_COEFF_CURRENT_IN   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEFF_PREVIOUS_IN  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEFF_PREVIOUS_OUT = 2'd2;

endpackage

### hdl/foiir_ram.sv
module foiir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/first_order_iir_filter_unit.sv
// channel   | direction | handshake                  | payload
// cfg       | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
// sample    | in        | sample_valid / sample_stall | channel, sample
// filtered  | out       | filtered_valid / filtered_stall | channel_out, filtered
//
// An accepted item passes the history-read and product stages to the output
// register; one item per cycle while channels differ and the output does not
// stall. An item whose channel matches one still in the memory read or multiply
// stage waits for its history write-back (memory read-modify-write) to be taken.
// Reset sets the coefficients to 1.0, 0, 0 and clears the per-channel valid
// bits, so all history reads as zero. A stalled output holds the whole pipe.
module first_order_iir_filter_unit
  import foiir_pkg::*;
#(
  parameter int CHANNELS        = CHANNELS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic signed [COEFF_BITS-1:0]  cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [CHAN_BITS-1:0]          channel,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          filtered_valid,
  input  logic                          filtered_stall,
  output logic [CHAN_BITS-1:0]          channel_out,
  output logic signed [SAMPLE_BITS-1:0] filtered
);

  localparam int AW    = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam int F     = COEFF_FRAC_BITS;
  localparam int SB    = SAMPLE_BITS;
  localparam int CW    = (F + 2 > COEFF_BITS) ? F + 2 : COEFF_BITS;
  localparam int P_W   = CW + SB;
  localparam int ACC_W = (P_W + 2 > F + SB + 1) ? P_W + 2 : F + SB + 1;

  localparam logic signed [CW-1:0]    C_UNITY = {{(CW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [ACC_W-1:0] RND     = {{(ACC_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SMAX    = {{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN    = {{(ACC_W-SB+1){1'b1}}, {(SB-1){1'b0}}};

  logic signed [CW-1:0] c0, c1, c2;
  logic [CHANNELS-1:0]  hist_valid;

  // stage 1: history read
  logic                 v1, ok1, hv1, fwd1;
  logic [CHAN_BITS-1:0] ch1;
  logic signed [SB-1:0] x1, fx1, fy1;
  // stage 2: products
  logic                 v2, ok2;
  logic [CHAN_BITS-1:0] ch2;
  logic signed [SB-1:0] x2;
  logic signed [P_W-1:0] pr0, pr1, pr2;

  logic                 accept, go1, go2, hazard, ok_in;
  logic [AW-1:0]        addr_in;
  logic [2*SB-1:0]      rdata;
  logic signed [SB-1:0] rx, ry, hx, hy, y_sat;
  logic signed [P_W-1:0] m0, m1, m2;
  logic signed [ACC_W-1:0] sum, shifted;

  assign cfg_ready = 1'b1;

  assign ok_in   = 32'(channel) < CHANNELS;
  assign addr_in = AW'(channel);

  assign go2    = v2 && (!filtered_valid || !filtered_stall);
  assign go1    = v1 && (!v2 || go2);
  assign hazard = (v1 && ch1 == channel) || (v2 && !go2 && ch2 == channel);
  assign sample_stall = (v1 && !go1) || hazard;
  assign accept = sample_valid && !sample_stall;

  foiir_ram #(
    .WIDTH (2 * SB),
    .DEPTH (CHANNELS)
  ) u_hist (
    .clk   (clk),
    .we    (go2 && ok2),
    .waddr (AW'(ch2)),
    .wdata ({x2, y_sat}),
    .re    (accept),
    .raddr (addr_in),
    .rdata (rdata)
  );

  assign rx = rdata[2*SB-1:SB];
  assign ry = rdata[SB-1:0];

  always_comb begin
    hx = '0;
    hy = '0;
    if (ok1) begin
      if (fwd1) begin
        hx = fx1;
        hy = fy1;
      end else if (hv1) begin
        hx = rx;
        hy = ry;
      end
    end
  end

  assign m0 = P_W'(c0) * P_W'(x1);
  assign m1 = P_W'(c1) * P_W'(hx);
  assign m2 = P_W'(c2) * P_W'(hy);

  assign sum     = ACC_W'(pr0) + ACC_W'(pr1) + ACC_W'(pr2) + RND;
  assign shifted = sum >>> F;

  always_comb begin
    if (shifted > SMAX) begin
      y_sat = SMAX[SB-1:0];
    end else if (shifted < SMIN) begin
      y_sat = SMIN[SB-1:0];
    end else begin
      y_sat = shifted[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c0 <= C_UNITY;
      c1 <= '0;
      c2 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COEFF_CURRENT_IN:   c0 <= CW'(cfg_data);
        CFG_COEFF_PREVIOUS_IN:  c1 <= CW'(cfg_data);
        CFG_COEFF_PREVIOUS_OUT: c2 <= CW'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid     <= '0;
      v1             <= 1'b0;
      v2             <= 1'b0;
      filtered_valid <= 1'b0;
    end else begin
      if (go2 && ok2) begin
        hist_valid[AW'(ch2)] <= 1'b1;
      end
      if (accept) begin
        v1 <= 1'b1;
      end else if (go1) begin
        v1 <= 1'b0;
      end
      if (go1) begin
        v2 <= 1'b1;
      end else if (go2) begin
        v2 <= 1'b0;
      end
      if (go2) begin
        filtered_valid <= 1'b1;
      end else if (!filtered_stall) begin
        filtered_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch1  <= channel;
      x1   <= sample;
      ok1  <= ok_in;
      hv1  <= ok_in && hist_valid[addr_in];
      // history of this channel written back on this very edge
      fwd1 <= go2 && ok2 && ch2 == channel;
      fx1  <= x2;
      fy1  <= y_sat;
    end
    if (go1) begin
      ch2 <= ch1;
      ok2 <= ok1;
      x2  <= x1;
      pr0 <= m0;
      pr1 <= m1;
      pr2 <= m2;
    end
    if (go2) begin
      channel_out <= ch2;
      filtered    <= y_sat;
    end
  end

endmodule
